### sv/pidff_pkg.sv
// Package: shared constants, types and saturation helpers of the PID controller.
`default_nettype none
package pidff_pkg;

    localparam int DATA_W = 32;
    localparam int WIDE_W = 52;
    localparam int Q_W    = 50;

    typedef logic signed [WIDE_W-1:0] t_wide;

    // loop constants: coefficients and error threshold Q16.16, tick count and tick rate plain integers
    localparam logic signed [31:0] SETPOINT_COEF_Q16   = 32'sd3121;
    localparam logic signed [31:0] DERIV_COEF_Q16      = 32'sd21845;
    localparam logic signed [31:0] ANTIWINDUP_STEP_Q16 = 32'sd655;
    localparam logic signed [31:0] CALM_ERROR_Q16      = 32'sd655;
    localparam logic [7:0]         CALM_TICKS          = 8'd160;
    localparam logic signed [16:0] TICK_RATE_HZ        = 17'sd20;

    // register reset values
    localparam logic signed [31:0] KP_RST    = 32'sd15729;
    localparam logic signed [31:0] KD_RST    = 32'sd196608;
    localparam logic signed [31:0] KI_RST    = 32'sd66;
    localparam logic signed [31:0] ALPHA_RST = 32'sd9830;
    localparam logic signed [31:0] IPG_RST   = 32'sd17246;
    localparam logic signed [31:0] CMIN_RST  = 32'sd0;
    localparam logic signed [31:0] CMAX_RST  = 32'sd19661;
    localparam logic [30:0]        SLEW_RST  = 31'd197;

    // register indexes
    localparam logic [2:0] CFG_KP    = 3'd0;
    localparam logic [2:0] CFG_KD    = 3'd1;
    localparam logic [2:0] CFG_KI    = 3'd2;
    localparam logic [2:0] CFG_ALPHA = 3'd3;
    localparam logic [2:0] CFG_IPG   = 3'd4;
    localparam logic [2:0] CFG_CMIN  = 3'd5;
    localparam logic [2:0] CFG_CMAX  = 3'd6;
    localparam logic [2:0] CFG_SLEW  = 3'd7;

    localparam t_wide S32_MAX = 52'sd2147483647;
    localparam t_wide S32_MIN = -52'sd2147483648;

    function automatic t_wide f_ext32(logic signed [31:0] x);
        return $signed({{(WIDE_W-32){x[31]}}, x});
    endfunction

    function automatic t_wide f_ext50(logic signed [Q_W-1:0] x);
        return $signed({{(WIDE_W-Q_W){x[Q_W-1]}}, x});
    endfunction

    function automatic logic signed [31:0] f_sat(t_wide x);
        logic signed [31:0] res;
        if (x > S32_MAX) res = 32'sh7fffffff;
        else if (x < S32_MIN) res = 32'sh80000000;
        else res = x[31:0];
        return res;
    endfunction

    // 33-bit signed difference a - b
    function automatic logic [32:0] f_diff33(logic signed [31:0] a, logic signed [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

endpackage
`default_nettype wire

### sv/pidff_if.sv
// Interfaces: input beat and result beat channels with valid/ready handshake.
`default_nettype none
interface pidff_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured_position;
    logic signed [31:0] target_position;
    logic signed [31:0] zero_reference;
    logic               direction_negative;

    modport source(output valid, measured_position, target_position, zero_reference,
                   direction_negative, input ready);
    modport sink(input valid, measured_position, target_position, zero_reference,
                 direction_negative, output ready);
endinterface

interface pidff_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] command;
    logic signed [31:0] unsaturated_sum;

    modport source(output valid, command, unsaturated_sum, input ready);
    modport sink(input valid, command, unsaturated_sum, output ready);
endinterface
`default_nettype wire

### sv/pid_with_feedforward_slew_limit.sv
// Top level: 2-DOF PID with feed-forward, clamp, slew limit and anti-windup.
// Timing: the one shared bit-serial multiplier sets the time from input beat to
//   result beat; each product runs through launch, multiply, round and update
//   steps, six to eight products per tick.
// Throughput: one beat at a time; the next input beat is taken once the
//   sequencer is back in idle; a result still waiting holds the following tick
//   at its output step.
// Reset: synchronous active-low; registers return to defaults, loop state clears.
`default_nettype none
module pid_with_feedforward_slew_limit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pidff_in_if.sink         i_in_beat,
    pidff_out_if.source      o_out_beat,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import pidff_pkg::*;

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_L_SP1 = 5'd1;
    localparam logic [4:0] S_L_SP2 = 5'd2;
    localparam logic [4:0] S_ERR   = 5'd3;
    localparam logic [4:0] S_VEL   = 5'd4;
    localparam logic [4:0] S_L_FV  = 5'd5;
    localparam logic [4:0] S_L_FF  = 5'd6;
    localparam logic [4:0] S_L_P   = 5'd7;
    localparam logic [4:0] S_L_D   = 5'd8;
    localparam logic [4:0] S_L_I   = 5'd9;
    localparam logic [4:0] S_SUM   = 5'd10;
    localparam logic [4:0] S_CLAMP = 5'd11;
    localparam logic [4:0] S_SLEW  = 5'd12;
    localparam logic [4:0] S_L_AW  = 5'd13;
    localparam logic [4:0] S_OUT   = 5'd14;
    localparam logic [4:0] S_MUL   = 5'd15;
    localparam logic [4:0] S_RND   = 5'd16;
    localparam logic [4:0] S_POST  = 5'd17;

    // product in flight
    localparam logic [2:0] OP_SP1 = 3'd0;
    localparam logic [2:0] OP_SP2 = 3'd1;
    localparam logic [2:0] OP_FV  = 3'd2;
    localparam logic [2:0] OP_FF  = 3'd3;
    localparam logic [2:0] OP_P   = 3'd4;
    localparam logic [2:0] OP_D   = 3'd5;
    localparam logic [2:0] OP_I   = 3'd6;
    localparam logic [2:0] OP_AW  = 3'd7;

    localparam int         MUL_STEPS = 33;
    localparam logic [5:0] CNT_LAST  = 6'(MUL_STEPS - 1);

    logic [4:0] r_state;
    logic [2:0] r_op;

    // configuration
    logic signed [31:0] r_kp, r_kd, r_ki, r_alpha, r_ipg, r_cmin, r_cmax;
    logic [30:0]        r_slew;

    // loop state
    logic signed [31:0] r_sp1, r_sp2, r_lm, r_fv, r_integ, r_lc;
    logic [7:0]         r_calm;
    logic               r_started;

    // per-tick working values
    logic signed [31:0] r_meas, r_tgt, r_zero;
    logic               r_neg;
    logic signed [31:0] r_ei, r_r, r_v, r_ff, r_p, r_d, r_u, r_cmd;

    // bit-serial multiplier: {hi, lo} shifts right one bit per cycle
    logic signed [31:0] r_ma;
    logic [32:0]        r_hi, r_lo;
    logic [5:0]         r_cnt;
    logic               r_k17;
    logic signed [Q_W-1:0] r_q;

    // result register
    logic               r_ov;
    logic signed [31:0] r_cmd_o, r_u_o;

    logic [33:0]           w_addend, w_hs;
    logic signed [65:0]    w_prod, w_rnd;
    logic signed [Q_W-1:0] w_q;
    logic signed [31:0]    w_e, w_ei;
    logic                  w_bypass, w_calm_hit;
    t_wide                 w_lo, w_hi, w_clip;

    // one partial product per cycle; the sign bit of b carries negative weight
    assign w_addend = !r_lo[0] ? 34'd0 :
                      (r_cnt == CNT_LAST) ? -{r_ma[31], r_ma[31], r_ma} :
                      {r_ma[31], r_ma[31], r_ma};
    assign w_hs     = {r_hi[32], r_hi} + w_addend;

    // round half up, then floor shift by 16 (17 for halved D)
    assign w_prod = $signed({r_hi, r_lo});
    assign w_rnd  = w_prod + (r_k17 ? 66'sd65536 : 66'sd32768);
    assign w_q    = r_k17 ? Q_W'(w_rnd >>> 17) : Q_W'(w_rnd >>> 16);

    assign w_e   = f_sat(f_ext32(r_sp2) - f_ext32(r_meas));
    assign w_ei  = f_sat(r_neg ? -f_ext32(w_e) : f_ext32(w_e));

    assign w_calm_hit = (r_ei > -CALM_ERROR_Q16) && (r_ei < CALM_ERROR_Q16);
    assign w_bypass   = r_calm > CALM_TICKS;

    // slew window around the last command
    assign w_lo   = f_ext32(r_lc) - $signed({21'b0, r_slew});
    assign w_hi   = f_ext32(r_lc) + $signed({21'b0, r_slew});
    assign w_clip = (f_ext32(r_cmd) < w_lo) ? w_lo :
                    (f_ext32(r_cmd) > w_hi) ? w_hi : f_ext32(r_cmd);

    assign i_in_beat.ready          = (r_state == S_IDLE);
    assign o_out_beat.valid         = r_ov;
    assign o_out_beat.command       = r_cmd_o;
    assign o_out_beat.unsaturated_sum = r_u_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_SP1;
            r_kp      <= KP_RST;
            r_kd      <= KD_RST;
            r_ki      <= KI_RST;
            r_alpha   <= ALPHA_RST;
            r_ipg     <= IPG_RST;
            r_cmin    <= CMIN_RST;
            r_cmax    <= CMAX_RST;
            r_slew    <= SLEW_RST;
            r_sp1     <= '0;
            r_sp2     <= '0;
            r_lm      <= '0;
            r_fv      <= '0;
            r_integ   <= '0;
            r_lc      <= '0;
            r_calm    <= '0;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KP:    r_kp    <= i_cfg_data;
                    CFG_KD:    r_kd    <= i_cfg_data;
                    CFG_KI:    r_ki    <= i_cfg_data;
                    CFG_ALPHA: r_alpha <= i_cfg_data;
                    CFG_IPG:   r_ipg   <= i_cfg_data;
                    CFG_CMIN:  r_cmin  <= i_cfg_data;
                    CFG_CMAX:  r_cmax  <= i_cfg_data;
                    CFG_SLEW:  r_slew  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            // the output step reloads the result itself when the old one drains
            if (r_ov && o_out_beat.ready && (r_state != S_OUT)) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_beat.valid) begin
                        r_meas  <= i_in_beat.measured_position;
                        r_tgt   <= i_in_beat.target_position;
                        r_zero  <= i_in_beat.zero_reference;
                        r_neg   <= i_in_beat.direction_negative;
                        // first tick seeds the filters and the slew reference
                        if (!r_started) begin
                            r_sp1     <= i_in_beat.target_position;
                            r_sp2     <= i_in_beat.target_position;
                            r_lm      <= i_in_beat.measured_position;
                            r_fv      <= '0;
                            r_lc      <= r_alpha;
                            r_started <= 1'b1;
                        end
                        r_state <= S_L_SP1;
                    end
                end
                S_L_SP1: begin
                    r_ma <= SETPOINT_COEF_Q16; r_lo <= f_diff33(r_tgt, r_sp1);
                    r_hi <= '0; r_cnt <= '0; r_k17 <= 1'b0; r_op <= OP_SP1;
                    r_state <= S_MUL;
                end
                S_L_SP2: begin
                    r_ma <= SETPOINT_COEF_Q16; r_lo <= f_diff33(r_sp1, r_sp2);
                    r_hi <= '0; r_cnt <= '0; r_k17 <= 1'b0; r_op <= OP_SP2;
                    r_state <= S_MUL;
                end
                S_ERR: begin
                    r_ei    <= w_ei;
                    r_r     <= f_sat(f_ext32(r_sp2) - f_ext32(r_zero));
                    r_state <= S_VEL;
                end
                S_VEL: begin
                    if (w_calm_hit) begin
                        if (r_calm != 8'hff) r_calm <= r_calm + 8'd1;
                    end else begin
                        r_calm <= '0;
                    end
                    r_v     <= f_sat((f_ext32(r_meas) - f_ext32(r_lm)) * TICK_RATE_HZ);
                    r_lm    <= r_meas;
                    r_state <= S_L_FV;
                end
                S_L_FV: begin
                    if (w_bypass) begin
                        r_fv    <= r_v;
                        r_state <= S_L_FF;
                    end else begin
                        r_ma <= DERIV_COEF_Q16; r_lo <= f_diff33(r_v, r_fv);
                        r_hi <= '0; r_cnt <= '0; r_k17 <= 1'b0; r_op <= OP_FV;
                        r_state <= S_MUL;
                    end
                end
                S_L_FF: begin
                    r_ma <= r_ipg; r_lo <= {r_r[31], r_r};
                    r_hi <= '0; r_cnt <= '0; r_k17 <= 1'b0; r_op <= OP_FF;
                    r_state <= S_MUL;
                end
                S_L_P: begin
                    r_ma <= r_kp; r_lo <= {r_ei[31], r_ei};
                    r_hi <= '0; r_cnt <= '0; r_k17 <= 1'b0; r_op <= OP_P;
                    r_state <= S_MUL;
                end
                S_L_D: begin
                    r_ma <= r_kd; r_lo <= {r_fv[31], r_fv};
                    r_hi <= '0; r_cnt <= '0; r_k17 <= w_bypass; r_op <= OP_D;
                    r_state <= S_MUL;
                end
                S_L_I: begin
                    r_ma <= r_ki; r_lo <= {r_ei[31], r_ei};
                    r_hi <= '0; r_cnt <= '0; r_k17 <= 1'b0; r_op <= OP_I;
                    r_state <= S_MUL;
                end
                S_SUM: begin
                    r_u <= f_sat(f_ext32(r_ff) + f_ext32(r_p) + f_ext32(r_d)
                                 + f_ext32(r_integ));
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    // cmin is tested first and wins for any sum below it
                    if (r_u < r_cmin)      r_cmd <= r_cmin;
                    else if (r_u > r_cmax) r_cmd <= r_cmax;
                    else                   r_cmd <= r_u;
                    r_state <= S_SLEW;
                end
                S_SLEW: begin
                    if (r_slew != '0) r_cmd <= f_sat(w_clip);
                    r_state <= S_L_AW;
                end
                S_L_AW: begin
                    if (r_ki > 32'sd0) begin
                        r_ma <= ANTIWINDUP_STEP_Q16; r_lo <= f_diff33(r_cmd, r_u);
                        r_hi <= '0; r_cnt <= '0; r_k17 <= 1'b0; r_op <= OP_AW;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out_beat.ready) begin
                        r_ov    <= 1'b1;
                        r_cmd_o <= r_cmd;
                        r_u_o   <= r_u;
                        r_lc    <= r_cmd;
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_hi  <= w_hs[33:1];
                    r_lo  <= {w_hs[0], r_lo[32:1]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == CNT_LAST) r_state <= S_RND;
                end
                S_RND: begin
                    r_q     <= w_q;
                    r_state <= S_POST;
                end
                S_POST: begin
                    unique case (r_op)
                        OP_SP1: begin
                            r_sp1 <= f_sat(f_ext32(r_sp1) + f_ext50(r_q));
                            r_state <= S_L_SP2;
                        end
                        OP_SP2: begin
                            r_sp2 <= f_sat(f_ext32(r_sp2) + f_ext50(r_q));
                            r_state <= S_ERR;
                        end
                        OP_FV: begin
                            r_fv <= f_sat(f_ext32(r_fv) + f_ext50(r_q));
                            r_state <= S_L_FF;
                        end
                        OP_FF: begin
                            r_ff <= f_sat(f_ext32(r_alpha) +
                                          (r_neg ? -f_ext50(r_q) : f_ext50(r_q)));
                            r_state <= S_L_P;
                        end
                        OP_P: begin
                            r_p <= f_sat(f_ext50(r_q));
                            r_state <= S_L_D;
                        end
                        OP_D: begin
                            r_d <= f_sat(r_neg ? f_ext50(r_q) : -f_ext50(r_q));
                            r_state <= S_L_I;
                        end
                        OP_I: begin
                            r_integ <= f_sat(f_ext32(r_integ) + f_ext50(r_q));
                            r_state <= S_SUM;
                        end
                        OP_AW: begin
                            r_integ <= f_sat(f_ext32(r_integ) + f_ext50(r_q));
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // an accepted beat always starts the sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_beat.valid && i_in_beat.ready) |=> (r_state == S_L_SP1))
        else $error("accepted beat did not start the sequence");

    // the multiplier never runs past its last bit
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= CNT_LAST))
        else $error("multiplier step count out of range");

    // a taken result is not shown again unless a new one is loaded
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_beat.valid && o_out_beat.ready && r_state != S_OUT) |=> !o_out_beat.valid)
        else $error("result beat repeated");

    // once started, the loop stays seeded
    a_started_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped");

endmodule
`default_nettype wire

### tb/sv/tb_pid_with_feedforward_slew_limit.sv
// Testbench for the PID controller: random and directed ticks checked against a local predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_pid_with_feedforward_slew_limit;
    import pidff_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 400;   // idle cycles after the last block

    typedef struct {
        logic signed [31:0] meas;
        logic signed [31:0] tgt;
        logic signed [31:0] zref;
        logic               dneg;
    } t_tick;

    typedef struct {
        logic signed [31:0] cmd;
        logic signed [31:0] sum;
    } t_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    pidff_in_if  in_bus ();
    pidff_out_if out_bus ();

    pid_with_feedforward_slew_limit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (in_bus),
        .o_out_beat (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Ticks waiting to be driven and commands waiting to come back
    t_tick tick_pend[$];
    t_cmd  cmd_due[$];
    t_tick cur_tick;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  send_hold;
    int  n_fail;
    int  n_ticks;
    int  n_cmds;
    int  n_calm_peak;
    longint cycles;

    // Controller shadow: registers
    longint r_kp, r_kd, r_ki, r_alpha, r_ipg, r_cmin, r_cmax, r_slew;
    // Controller shadow: loop state
    longint s_sp1, s_sp2, s_last_meas, s_fvel, s_integ, s_last_cmd;
    int     s_calm;
    bit     s_started;

    // Generator-side setpoint tracking, used to build calm sequences
    longint g_sp1, g_sp2;
    bit     g_started;

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Round half up, floor shift by k
    function automatic longint mulq(longint a, longint b, int k);
        longint p;
        p = a * b + (64'sd1 <<< (k - 1));
        return p >>> k;
    endfunction

    function automatic longint clampv(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // One control tick: update the shadow state and return the command beat
    function automatic t_cmd control_tick(t_tick t);
        longint meas, tgt, zref, e, ei, r, v, m, ff, p, d, u, c;
        bit     bypass;
        t_cmd   res;
        meas = longint'(t.meas);
        tgt  = longint'(t.tgt);
        zref = longint'(t.zref);
        if (!s_started) begin
            s_sp1 = tgt;
            s_sp2 = tgt;
            s_last_meas = meas;
            s_fvel = 0;
            s_last_cmd = r_alpha;
            s_started = 1'b1;
        end
        s_sp1 = sat32(s_sp1 + mulq(longint'(SETPOINT_COEF_Q16), tgt - s_sp1, 16));
        s_sp2 = sat32(s_sp2 + mulq(longint'(SETPOINT_COEF_Q16), s_sp1 - s_sp2, 16));
        e  = sat32(s_sp2 - meas);
        ei = sat32(t.dneg ? -e : e);
        r  = sat32(s_sp2 - zref);
        if ((ei < 0 ? -ei : ei) < longint'(CALM_ERROR_Q16)) begin
            if (s_calm < 255) s_calm++;
        end else begin
            s_calm = 0;
        end
        if (s_calm > n_calm_peak) n_calm_peak = s_calm;
        bypass = s_calm > int'(CALM_TICKS);
        v = sat32((meas - s_last_meas) * longint'(TICK_RATE_HZ));
        s_last_meas = meas;
        if (bypass) s_fvel = v;
        else s_fvel = sat32(s_fvel + mulq(longint'(DERIV_COEF_Q16), v - s_fvel, 16));
        m  = mulq(r_ipg, r, 16);
        ff = sat32(r_alpha + (t.dneg ? -m : m));
        p  = sat32(mulq(r_kp, ei, 16));
        m  = mulq(r_kd, s_fvel, bypass ? 17 : 16);
        d  = sat32(t.dneg ? m : -m);
        s_integ = sat32(s_integ + mulq(r_ki, ei, 16));
        u = sat32(ff + p + d + s_integ);
        // clamp first, then slew window; both test the low bound first
        c = clampv(u, r_cmin, r_cmax);
        if (r_slew > 0) c = sat32(clampv(c, s_last_cmd - r_slew, s_last_cmd + r_slew));
        // back-calculation only with a positive integral gain
        if (r_ki > 0 && longint'(ANTIWINDUP_STEP_Q16) > 0)
            s_integ = sat32(s_integ + mulq(longint'(ANTIWINDUP_STEP_Q16), c - u, 16));
        s_last_cmd = c;
        res.cmd = c[31:0];
        res.sum = u[31:0];
        return res;
    endfunction

    // Queue a tick and keep the generator's setpoint copy in step
    task automatic queue_tick(logic signed [31:0] meas, logic signed [31:0] tgt,
                              logic signed [31:0] zref, logic dneg);
        t_tick t;
        longint tg;
        t.meas = meas; t.tgt = tgt; t.zref = zref; t.dneg = dneg;
        tg = longint'(tgt);
        if (!g_started) begin
            g_sp1 = tg; g_sp2 = tg; g_started = 1'b1;
        end
        g_sp1 = sat32(g_sp1 + mulq(longint'(SETPOINT_COEF_Q16), tg - g_sp1, 16));
        g_sp2 = sat32(g_sp2 + mulq(longint'(SETPOINT_COEF_Q16), g_sp1 - g_sp2, 16));
        tick_pend.push_back(t);
    endtask

    // Measurement that lands close to the filtered setpoint of this tick
    task automatic queue_near(logic signed [31:0] tgt, int spread);
        longint nsp1, nsp2, meas;
        nsp1 = g_started ? sat32(g_sp1 + mulq(longint'(SETPOINT_COEF_Q16),
                                             longint'(tgt) - g_sp1, 16)) : longint'(tgt);
        nsp2 = g_started ? sat32(g_sp2 + mulq(longint'(SETPOINT_COEF_Q16),
                                             nsp1 - g_sp2, 16)) : longint'(tgt);
        meas = sat32(nsp2 + longint'($urandom_range(0, 2 * spread)) - spread);
        queue_tick(meas[31:0], tgt, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_KP:    r_kp    = longint'($signed(val));
            CFG_KD:    r_kd    = longint'($signed(val));
            CFG_KI:    r_ki    = longint'($signed(val));
            CFG_ALPHA: r_alpha = longint'($signed(val));
            CFG_IPG:   r_ipg   = longint'($signed(val));
            CFG_CMIN:  r_cmin  = longint'($signed(val));
            CFG_CMAX:  r_cmax  = longint'($signed(val));
            CFG_SLEW:  r_slew  = longint'(val[30:0]);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] kp, logic [31:0] kd, logic [31:0] ki,
                             logic [31:0] al, logic [31:0] ipg, logic [31:0] cmn,
                             logic [31:0] cmx, logic [31:0] slw);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KD, kd);
        write_reg(CFG_KI, ki);
        write_reg(CFG_ALPHA, al);
        write_reg(CFG_IPG, ipg);
        write_reg(CFG_CMIN, cmn);
        write_reg(CFG_CMAX, cmx);
        write_reg(CFG_SLEW, slw);
    endtask

    // Wait until every queued tick went in and every command came back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (tick_pend.size() != 0 || in_bus.valid || cmd_due.size() != 0);
    endtask

    // Sender: one beat in flight, presented from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                cmd_due.push_back(control_tick(cur_tick));
                n_ticks++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (tick_pend.size() != 0 && !send_hold &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_tick = tick_pend.pop_front();
                    in_bus.valid              <= 1'b1;
                    in_bus.measured_position  <= cur_tick.meas;
                    in_bus.target_position    <= cur_tick.tgt;
                    in_bus.zero_reference     <= cur_tick.zref;
                    in_bus.direction_negative <= cur_tick.dneg;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, each command beat checked against the oldest prediction
    always @(posedge i_clk) begin
        t_cmd want;
        if (out_bus.valid && out_bus.ready && i_rst_n) begin
            if (cmd_due.size() == 0) begin
                $error("unexpected command beat: command %0d sum %0d",
                       out_bus.command, out_bus.unsaturated_sum);
                n_fail++;
            end else begin
                want = cmd_due.pop_front();
                if (out_bus.command !== want.cmd) begin
                    $error("command: expected %0d, got %0d", want.cmd, out_bus.command);
                    n_fail++;
                end
                if (out_bus.unsaturated_sum !== want.sum) begin
                    $error("unsaturated_sum: expected %0d, got %0d",
                           want.sum, out_bus.unsaturated_sum);
                    n_fail++;
                end
            end
            n_cmds++;
        end
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int blk, k, mode;
        logic signed [31:0] hold_tgt;
        in_bus.valid = 1'b0;
        in_bus.measured_position = '0;
        in_bus.target_position = '0;
        in_bus.zero_reference = '0;
        in_bus.direction_negative = 1'b0;
        out_bus.ready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; send_hold = 1'b0;
        n_fail = 0; n_ticks = 0; n_cmds = 0; n_calm_peak = 0; cycles = 0;
        r_kp = KP_RST; r_kd = KD_RST; r_ki = KI_RST; r_alpha = ALPHA_RST;
        r_ipg = IPG_RST; r_cmin = CMIN_RST; r_cmax = CMAX_RST; r_slew = SLEW_RST;
        s_sp1 = 0; s_sp2 = 0; s_last_meas = 0; s_fvel = 0; s_integ = 0;
        s_last_cmd = 0; s_calm = 0; s_started = 1'b0;
        g_started = 1'b0; g_sp1 = 0; g_sp2 = 0;

        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first tick seeds the filters under reset gains
        queue_tick(32'sd1000, 32'sd5000, 32'sd0, 1'b0);
        queue_tick(32'sd0, 32'sd5000, 32'sd0, 1'b1);
        queue_tick(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
        queue_tick(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b1);
        queue_tick(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0);
        queue_tick(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b1);
        queue_tick(32'sh0, 32'sh0, 32'sh0, 1'b0);
        queue_tick(32'shffffffff, 32'sh1, 32'shffffffff, 1'b1);
        queue_tick(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 1'b0);
        queue_tick(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 1'b1);
        wait_drained();

        // Extremes: inverted limits, slew off, negative integral gain, then the opposite extremes
        write_all(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
        for (k = 0; k < 6; k++)
            queue_tick($urandom, $urandom, $urandom, k[0]);
        wait_drained();
        write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        for (k = 0; k < 6; k++)
            queue_tick($urandom, $urandom, $urandom, k[0]);
        wait_drained();

        // Random blocks, each with a register set and one of four handshake pressure mixes
        for (blk = 0; blk < 8; blk++) begin
            case (blk)
                0: write_all(KP_RST, KD_RST, KI_RST, ALPHA_RST, IPG_RST,
                             CMIN_RST, CMAX_RST, {1'b0, SLEW_RST});
                1: write_all($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
                // anti-windup off, slew off, for the calm run
                2: write_all(32'd40000, 32'd98304, 32'd0, 32'd9830, 32'd17246,
                             32'hfff00000, 32'h00100000, 32'd0);
                3: write_all(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0,
                             32'h7fffffff, 32'h00010000, 32'hffff0000, 32'h7fffffff);
                4: write_all(32'h7fffffff, 32'h1, 32'h7fffffff, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h7fffffff, 32'd1);
                6: write_all(KP_RST, KD_RST, KI_RST, ALPHA_RST, IPG_RST,
                             32'hffff0000, 32'h00020000, 32'd5000);
                default: write_all($urandom_range(0, 200000), $urandom, $urandom_range(0, 5000),
                                   $urandom, $urandom_range(0, 70000), 32'hfff00000,
                                   $urandom_range(0, 32'h00200000), $urandom_range(0, 20000));
            endcase
            case (blk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            hold_tgt = g_sp2[31:0];
            if (blk == 2 || blk == 6) begin
                // long calm run: drives the derivative bypass
                for (k = 0; k < 170; k++) queue_near(hold_tgt, 300);
                queue_near(hold_tgt, 100000);
            end
            for (k = 0; k < 36; k++) begin
                mode = $urandom_range(0, 99);
                if (mode < 15) begin
                    queue_tick($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
                end else if (mode < 75) begin
                    hold_tgt = hold_tgt + $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
                    queue_near(hold_tgt, 16384);
                end else begin
                    queue_near(hold_tgt, 300);
                end
            end
            if (blk == 1) begin
                // sender waits for every command before resuming
                send_hold = 1'b1;
                do @(posedge i_clk);
                while (in_bus.valid || cmd_due.size() != 0);
                send_hold = 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d ticks in, %0d commands out, ten register sets, four pressure mixes",
                 n_ticks, n_cmds);
        $display("longest calm streak %0d ticks (bypass beyond %0d)", n_calm_peak, CALM_TICKS);
        if (n_fail == 0 && cmd_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d commands missing", n_fail, cmd_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
